>>> hdl/hce_pkg.sv
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types and constants for the hill cipher encryptor.
// ----------------------------------------------------------------------------
package hce_pkg;

    localparam int LETTER_W    = 5;
    localparam int KEY_ROWS    = 7;
    localparam int ROW_IDX_W   = 3;
    localparam int ROW_W       = KEY_ROWS * LETTER_W;
    localparam int KSIZE_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int ACC_W       = 13;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 20;
    localparam int QUOT_W      = 8;
    localparam int DATA_W      = 8;

    localparam logic [LETTER_W-1:0]  ALPHABET    = 5'd26;
    localparam logic [LETTER_W-1:0]  PAD_LETTER  = 5'd23;
    localparam logic [RECIP_W-1:0]   RECIP_26    = 16'd40330;
    localparam logic [KSIZE_W-1:0]   KSIZE_RESET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_QUO,
        ST_REM,
        ST_OUT
    } state_t;

    function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        r = (v >= ALPHABET) ? v - ALPHABET : v;
        return r;
    endfunction

endpackage

>>> hdl/hill_cipher_encrypt.sv
// ----------------------------------------------------------------------------
// hill_cipher_encrypt
// Hill cipher encryptor: collects n letters (fewer if tlast ends the block,
// padded), then emits n cipher letters. A letter that does not close a block
// is stored, and the input stays ready for the next one. Each cipher letter
// takes n multiply-accumulate steps on the single shared unit, a quotient
// step, a remainder step and an output step that waits for the output ready.
// Reset (async, active low) empties the block, sets n = 3 and an identity key.
// ----------------------------------------------------------------------------
module hill_cipher_encrypt #(
    parameter int MAX_KEY_SIZE = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hce_pkg::ROW_W-1:0]       cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [hce_pkg::DATA_W-1:0]      s_axis_tdata,   // plain_letter [4:0], zero [7:5]
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hce_pkg::DATA_W-1:0]      m_axis_tdata,   // cipher_letter [4:0], zero [7:5]
    output logic                            m_axis_tlast,
    output logic [0:0]                      m_axis_tuser    // block_end [0]
);

    localparam int IDX_W = (MAX_KEY_SIZE > 1) ? $clog2(MAX_KEY_SIZE) : 1;
    localparam int CNT_W = $clog2(MAX_KEY_SIZE + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEY_SIZE);

    hce_pkg::state_t                      state_reg, state_next;
    logic [CNT_W-1:0]                     fill_reg, fill_next;
    logic [CNT_W-1:0]                     count_reg, count_next;
    logic [IDX_W-1:0]                     row_reg, row_next;
    logic [IDX_W-1:0]                     col_reg, col_next;
    logic                                 last_reg, last_next;
    logic [hce_pkg::ACC_W-1:0]            acc_reg, acc_next;
    logic [hce_pkg::QUOT_W-1:0]           quot_reg, quot_next;
    logic [hce_pkg::LETTER_W-1:0]         letter_reg, letter_next;
    logic                                 bend_reg, bend_next;
    logic                                 mend_reg, mend_next;
    logic [hce_pkg::KSIZE_W-1:0]          key_size_reg;
    logic [hce_pkg::ROW_W-1:0]            key_row_reg [hce_pkg::KEY_ROWS];
    logic [hce_pkg::LETTER_W-1:0]         store_reg [MAX_KEY_SIZE];

    logic                                 in_req;
    logic [hce_pkg::LETTER_W-1:0]         in_letter;
    logic [CNT_W-1:0]                     n_act;
    logic [CNT_W-1:0]                     cnt_inc;
    logic                                 col_end;
    logic                                 row_end;
    logic [hce_pkg::ROW_W-1:0]            key_word;
    logic [hce_pkg::LETTER_W-1:0]         key_raw;
    logic [hce_pkg::LETTER_W-1:0]         key_ent;
    logic [hce_pkg::LETTER_W-1:0]         plain_ent;
    logic [2*hce_pkg::LETTER_W-1:0]       mac_prod;
    logic [hce_pkg::ACC_W+hce_pkg::RECIP_W-1:0] recip_prod;
    logic [hce_pkg::ACC_W-1:0]            rem_val;

    assign in_req    = s_axis_tvalid && s_axis_tready;
    assign in_letter = hce_pkg::fold_letter(s_axis_tdata[hce_pkg::LETTER_W-1:0]);

    always_comb
    begin
        if (key_size_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (key_size_reg > hce_pkg::KSIZE_W'(MAX_KEY_SIZE))
        begin
            n_act = MAX_CNT;
        end
        else
        begin
            n_act = CNT_W'(key_size_reg);
        end
    end

    assign cnt_inc = fill_reg + CNT_W'(1);
    assign col_end = (CNT_W'(col_reg) + CNT_W'(1)) == n_act;
    assign row_end = (CNT_W'(row_reg) + CNT_W'(1)) == n_act;

    // shared multiply-accumulate operands
    assign key_word  = key_row_reg[hce_pkg::ROW_IDX_W'(row_reg)];
    assign key_raw   = key_word[hce_pkg::ROW_IDX_W'(col_reg) * hce_pkg::LETTER_W +: hce_pkg::LETTER_W];
    assign key_ent   = hce_pkg::fold_letter(key_raw);
    assign plain_ent = (CNT_W'(col_reg) < count_reg) ? store_reg[col_reg] : hce_pkg::PAD_LETTER;
    assign mac_prod  = key_ent * plain_ent;

    // modulo 26 through a reciprocal multiply
    assign recip_prod = acc_reg * hce_pkg::RECIP_26;
    assign rem_val    = acc_reg - hce_pkg::ACC_W'(quot_reg) * hce_pkg::ACC_W'(hce_pkg::ALPHABET);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        last_next   = last_reg;
        acc_next    = acc_reg;
        quot_next   = quot_reg;
        letter_next = letter_reg;
        bend_next   = bend_reg;
        mend_next   = mend_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            hce_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (cnt_inc >= n_act || s_axis_tlast)
                    begin
                        count_next = cnt_inc;
                        last_next  = s_axis_tlast;
                        fill_next  = '0;
                        row_next   = '0;
                        col_next   = '0;
                        acc_next   = '0;
                        state_next = hce_pkg::ST_MAC;
                    end
                    else
                    begin
                        fill_next = cnt_inc;
                    end
                end
            end
            hce_pkg::ST_MAC:
            begin
                acc_next = acc_reg + hce_pkg::ACC_W'(mac_prod);
                if (col_end)
                begin
                    state_next = hce_pkg::ST_QUO;
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            hce_pkg::ST_QUO:
            begin
                quot_next  = recip_prod[hce_pkg::RECIP_SHIFT +: hce_pkg::QUOT_W];
                state_next = hce_pkg::ST_REM;
            end
            hce_pkg::ST_REM:
            begin
                letter_next = rem_val[hce_pkg::LETTER_W-1:0];
                bend_next   = row_end;
                mend_next   = row_end && last_reg;
                state_next  = hce_pkg::ST_OUT;
            end
            hce_pkg::ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    if (row_end)
                    begin
                        state_next = hce_pkg::ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + IDX_W'(1);
                        col_next   = '0;
                        acc_next   = '0;
                        state_next = hce_pkg::ST_MAC;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hce_pkg::ST_IDLE;
            fill_reg   <= '0;
            count_reg  <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            last_reg   <= 1'b0;
            acc_reg    <= '0;
            quot_reg   <= '0;
            letter_reg <= '0;
            bend_reg   <= 1'b0;
            mend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            last_reg   <= last_next;
            acc_reg    <= acc_next;
            quot_reg   <= quot_next;
            letter_reg <= letter_next;
            bend_reg   <= bend_next;
            mend_reg   <= mend_next;
        end
    end

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= hce_pkg::KSIZE_RESET;
            for (int r = 0; r < hce_pkg::KEY_ROWS; r++)
            begin
                key_row_reg[r] <= hce_pkg::ROW_W'(1) << (r * hce_pkg::LETTER_W);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == hce_pkg::CFG_KEY_SIZE)
            begin
                key_size_reg <= cfg_data[hce_pkg::KSIZE_W-1:0];
            end
            else
            begin
                key_row_reg[cfg_index - hce_pkg::CFG_IDX_W'(1)] <= cfg_data;
            end
        end
    end

    // block letter store
    always_ff @(posedge clk)
    begin
        if (in_req && fill_reg < MAX_CNT)
        begin
            store_reg[fill_reg[IDX_W-1:0]] <= in_letter;
        end
    end

    assign m_axis_tdata = hce_pkg::DATA_W'(letter_reg);
    assign m_axis_tlast = mend_reg;
    assign m_axis_tuser = bend_reg;

endmodule

>>> hdl/hce_checker.sv
// ----------------------------------------------------------------------------
// hce_checker
// Port-level checks for the hill cipher encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module hce_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        s_axis_tlast,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [hce_pkg::DATA_W-1:0]  m_axis_tdata,
    input logic                        m_axis_tlast,
    input logic [0:0]                  m_axis_tuser
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // cipher letter is always a to z
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[hce_pkg::LETTER_W-1:0] < hce_pkg::ALPHABET)
                          && (m_axis_tdata[hce_pkg::DATA_W-1:hce_pkg::LETTER_W] == '0))
        else $error("cipher letter out of range");

    // no new request taken while a result is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while output pending");

    // message end only on a block end
    a_end_nest: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("message end without block end");

    // last letter of a message always starts encryption
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("last letter did not close the block");

endmodule

bind hill_cipher_encrypt hce_checker u_hce_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams plaintext letters into hill_cipher_encrypt under a series of keys
// and block sizes. A letter-level Hill cipher predictor builds the expected
// cipher letters, and each one is checked against the output stream. Both
// stream sides stall at random, and one long output hold-off forces a stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_KEY      = 7;
    localparam int GAP_MAX      = 14;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 36;
    localparam int HOLD_CYCLES  = 600;
    localparam logic [hce_pkg::CFG_IDX_W-1:0] CFG_KEY_ROW_0 = 3'd1;

    typedef struct packed {
        logic [hce_pkg::LETTER_W-1:0] letter;
        logic                         message_last;
    } plain_t;

    typedef struct packed {
        logic [hce_pkg::LETTER_W-1:0] letter;
        logic                         block_end;
        logic                         message_end;
    } cipher_t;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          cfg_we        = 1'b0;
    logic [hce_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [hce_pkg::ROW_W-1:0]     cfg_data      = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [hce_pkg::DATA_W-1:0]    s_axis_tdata  = '0;   // plain_letter [4:0], zero [7:5]
    logic                          s_axis_tlast  = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [hce_pkg::DATA_W-1:0]    m_axis_tdata;         // cipher_letter [4:0], zero [7:5]
    logic                          m_axis_tlast;
    logic [0:0]                    m_axis_tuser;         // block_end [0]

    // predictor state
    logic [hce_pkg::KSIZE_W-1:0]  key_size_q = hce_pkg::KSIZE_RESET;
    logic [hce_pkg::ROW_W-1:0]    key_rows_q [hce_pkg::KEY_ROWS];
    logic [hce_pkg::ROW_W-1:0]    staged_rows [hce_pkg::KEY_ROWS];
    logic [hce_pkg::LETTER_W-1:0] held_letters [MAX_KEY];
    int                           held_count = 0;

    plain_t  plain_q [$];
    cipher_t cipher_q [$];
    cipher_t expected_cipher;

    plain_t next_item;
    logic   item_ready    = 1'b0;
    int     send_wait     = 0;
    int     send_gap_max  = 0;
    int     recv_wait     = 0;
    int     recv_gap_max  = 0;
    int     hold_request  = 0;
    int     hold_left     = 0;

    int failures       = 0;
    int letters_sent   = 0;
    int ciphers_seen   = 0;
    int key_settings   = 0;
    int cycle_count    = 0;

    hill_cipher_encrypt dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("hill_cipher_encrypt regression: fail");
            $finish;
        end
    end

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= REPORT_MAX)
            $display("mismatch: %s", msg);
    endtask

    // one plaintext letter into the block; a full or closed block yields n cipher letters
    task automatic encrypt_letter(input logic [hce_pkg::LETTER_W-1:0] raw,
                                  input logic msg_last);
        int n;
        int count;
        int acc;
        int entry;
        int p;
        int i;
        int j;
        cipher_t c;
        n = (key_size_q == '0) ? 1 : int'(key_size_q);
        count = held_count;
        if (count < MAX_KEY)
            held_letters[count] = raw % hce_pkg::ALPHABET;
        count++;
        if (count < n && !msg_last)
            held_count = count;
        else
        begin
            for (i = 0; i < n; i++)
            begin
                acc = 0;
                for (j = 0; j < n; j++)
                begin
                    entry = int'(key_rows_q[i][hce_pkg::LETTER_W*j +: hce_pkg::LETTER_W]);
                    p = (j < count) ? int'(held_letters[j]) : int'(hce_pkg::PAD_LETTER);
                    acc = (acc + (entry % int'(hce_pkg::ALPHABET)) * p)
                          % int'(hce_pkg::ALPHABET);
                end
                c.letter      = acc[hce_pkg::LETTER_W-1:0];
                c.block_end   = (i == n - 1);
                c.message_end = (i == n - 1) && msg_last;
                cipher_q.push_back(c);
            end
            held_count = 0;
        end
    endtask

    // block size and all key rows, written back to back while idle
    task automatic load_key(input int size);
        int r;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= hce_pkg::CFG_KEY_SIZE;
        cfg_data  <= hce_pkg::ROW_W'(size);
        key_size_q = hce_pkg::KSIZE_W'(size);
        for (r = 0; r < hce_pkg::KEY_ROWS; r++)
        begin
            @(posedge clk);
            cfg_index <= CFG_KEY_ROW_0 + hce_pkg::CFG_IDX_W'(r);
            cfg_data  <= staged_rows[r];
            key_rows_q[r] = staged_rows[r];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        key_settings++;
        @(negedge clk);
    endtask

    function automatic logic [hce_pkg::ROW_W-1:0] random_row();
        logic [hce_pkg::ROW_W-1:0] row;
        int j;
        if ($urandom_range(0, 3) == 0)
        begin
            row[31:0]                = $urandom;
            row[hce_pkg::ROW_W-1:32] = 3'($urandom_range(0, 7));
        end
        else
            for (j = 0; j < hce_pkg::KEY_ROWS; j++)
                row[hce_pkg::LETTER_W*j +: hce_pkg::LETTER_W] = ($urandom_range(0, 11) == 0) ?
                    hce_pkg::LETTER_W'($urandom_range(26, 31)) :
                    hce_pkg::LETTER_W'($urandom_range(0, 25));
        return row;
    endfunction

    task automatic queue_letter(input int letter, input logic msg_last);
        plain_t item;
        item.letter       = hce_pkg::LETTER_W'(letter);
        item.message_last = msg_last;
        plain_q.push_back(item);
    endtask

    task automatic wait_quiet();
        while (plain_q.size() != 0 || item_ready || s_axis_tvalid || cipher_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // plaintext driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                encrypt_letter(s_axis_tdata[hce_pkg::LETTER_W-1:0], s_axis_tlast);
                letters_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (!item_ready && plain_q.size() > 0)
                begin
                    next_item  = plain_q.pop_front();
                    send_wait  = $urandom_range(0, send_gap_max);
                    item_ready = 1'b1;
                end
                if (item_ready && send_wait == 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(hce_pkg::DATA_W-hce_pkg::LETTER_W){1'b0}},
                                      next_item.letter};
                    s_axis_tlast  <= next_item.message_last;
                    item_ready = 1'b0;
                end
                else
                begin
                    if (item_ready)
                        send_wait--;
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_request > 0)
        begin
            hold_left    <= hold_request;
            hold_request = 0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // cipher monitor and output stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                ciphers_seen++;
                if (cipher_q.size() == 0)
                    report_failure($sformatf("cipher letter %0d arrived with nothing expected",
                                             m_axis_tdata));
                else
                begin
                    expected_cipher = cipher_q.pop_front();
                    if (m_axis_tdata !== {{(hce_pkg::DATA_W-hce_pkg::LETTER_W){1'b0}},
                                          expected_cipher.letter} ||
                        m_axis_tuser[0] !== expected_cipher.block_end ||
                        m_axis_tlast !== expected_cipher.message_end)
                        report_failure($sformatf(
                            "cipher %0d: want %0d/%0b/%0b got %0d/%0b/%0b (letter/blk/msg)",
                            ciphers_seen, expected_cipher.letter, expected_cipher.block_end,
                            expected_cipher.message_end, m_axis_tdata, m_axis_tuser[0],
                            m_axis_tlast));
                end
                recv_wait = $urandom_range(0, recv_gap_max);
            end
            if (hold_left > 0)
                m_axis_tready <= 1'b0;
            else if (recv_wait > 0)
            begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int sizes [8] = '{1, 7, 0, 4, 2, 5, 7, 3};
        int phase;
        int queued;
        int len;
        int k;
        int letter;
        logic broken;
        for (k = 0; k < hce_pkg::KEY_ROWS; k++)
        begin
            key_rows_q[k] = '0;
            key_rows_q[k][hce_pkg::LETTER_W*k] = 1'b1;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset key: identity, block of 3; out-of-range letters, padding, exact fill
        queue_letter(0, 1'b0);
        queue_letter(25, 1'b0);
        queue_letter(31, 1'b1);
        queue_letter(26, 1'b1);
        queue_letter(7, 1'b0);
        queue_letter(19, 1'b0);
        queue_letter(3, 1'b1);
        wait_quiet();

        // block size zero behaves as one; all key entries out of range
        foreach (staged_rows[r])
            staged_rows[r] = '1;
        load_key(0);
        queue_letter(30, 1'b0);
        queue_letter(12, 1'b1);
        wait_quiet();

        // widest block, largest in-range entries
        foreach (staged_rows[r])
            staged_rows[r] = {hce_pkg::KEY_ROWS{5'd25}};
        load_key(7);
        for (k = 0; k < 7; k++)
            queue_letter(25, k == 6);
        wait_quiet();

        // shrink the block while letters are held
        foreach (staged_rows[r])
            staged_rows[r] = random_row();
        staged_rows[3] = '0;
        load_key(7);
        for (k = 0; k < 5; k++)
            queue_letter($urandom_range(0, 25), 1'b0);
        wait_quiet();
        load_key(2);
        queue_letter(9, 1'b0);
        wait_quiet();

        // random messages under random keys
        for (phase = 0; phase < 8; phase++)
        begin
            foreach (staged_rows[r])
                staged_rows[r] = random_row();
            load_key(sizes[phase]);
            send_gap_max = (phase % 3 == 1) ? 0 : GAP_MAX;
            recv_gap_max = (phase % 3 == 2) ? 0 : GAP_MAX;
            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 20);
                broken = ($urandom_range(0, 7) == 0);
                for (k = 0; k < len; k++)
                begin
                    letter = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 31)
                                                         : $urandom_range(0, 25);
                    queue_letter(letter, (k == len - 1) && !broken);
                end
                queued += len;
            end
            // output held off while the sender keeps going
            if (phase == 1)
                hold_request = HOLD_CYCLES;
            wait_quiet();
        end

        $display("sent %0d plaintext letters under %0d key settings (block sizes 0..7)",
                 letters_sent, key_settings);
        $display("checked %0d cipher letters, %0d mismatches, %0d still expected",
                 ciphers_seen, failures, cipher_q.size());
        if (failures == 0 && cipher_q.size() == 0)
            $display("hill_cipher_encrypt regression: pass");
        else
            $display("hill_cipher_encrypt regression: fail");
        $finish;
    end

endmodule
